@@ rtl/dpb_pkg.sv @@
// Package for the depth pixel back-projection block: field widths, limits,
// register indexes and the payload and divider types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

    localparam int SUBSAMPLE_STEP_DEF = 3;
    localparam int MAX_IMAGE_SIZE_DEF = 4096;

    localparam int PIX_W     = 12;
    localparam int DEPTH_W   = 16;
    localparam int COLOUR_W  = 8;
    localparam int COORD_W   = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int QUOT_W             = COORD_W;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

    localparam logic signed [COORD_W-1:0] POS_LIMIT = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] NEG_LIMIT = 24'sh800000;

    localparam logic [CFG_W-1:0] PRINCIPAL_X_RST = 16'd5112;
    localparam logic [CFG_W-1:0] PRINCIPAL_Y_RST = 16'd3832;
    localparam logic [CFG_W-1:0] FOCAL_X_RST     = 16'd8400;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 16'd8400;
    localparam logic [CFG_W-1:0] MIN_DEPTH_RST   = 16'd41;
    localparam logic [CFG_W-1:0] MAX_DEPTH_RST   = 16'd20480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRINCIPAL_X = 3'd0,
        CFG_PRINCIPAL_Y = 3'd1,
        CFG_FOCAL_X     = 3'd2,
        CFG_FOCAL_Y     = 3'd3,
        CFG_MIN_DEPTH   = 3'd4,
        CFG_MAX_DEPTH   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0]    row;
        logic [PIX_W-1:0]    column;
        logic [DEPTH_W-1:0]  depth;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic [COLOUR_W-1:0]       out_blue;
        logic [COLOUR_W-1:0]       out_green;
        logic [COLOUR_W-1:0]       out_red;
    } t_point;

    // depth and colour carried alongside the arithmetic
    typedef struct packed {
        logic [DEPTH_W-1:0]  z;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } t_side;

    // one coordinate in the restoring divider
    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic               zero;
        logic [CFG_W-1:0]   rem;
        logic [QUOT_W-1:0]  work;
    } t_div;

endpackage

`default_nettype wire

@@ rtl/dpb_stream_if.sv @@
// Valid/ready stream interface with a typed payload.
// Used for the pixel input and the point output; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dpb_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/depth_pixel_backprojection.sv @@
// Top level of the depth pixel back-projection pipeline.
// Depends on dpb_pkg and dpb_stream_if.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel per clock while the output is not stalled and, for pixels
// on the subsample grid whose depth lies in [min_depth, max_depth], emits
// x = (16*column - cx) * z / fx and y = (16*row - cy) * z / fy in signed
// Q11.12 metres, truncated toward zero and saturated, with z and the colour
// bytes. Sustained rate is one pixel per cycle when not stalled; a pixel
// passes the input register, offsets, range test and grid quotient, grid
// test and two multipliers, quotient overflow check, six divider stages of
// four quotient bits each, and the saturating output register. Dropped
// pixels leave a bubble only. A stalled output freezes the whole pipeline.
// Write the registers only while the pipeline is empty.
module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF,
    parameter int MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    dpb_stream_if.sink                i_pixel,
    dpb_stream_if.source              o_point
);

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RPROD_W     = PIX_W + RECIP_W;
    localparam int MAG_W       = CFG_W + 1;
    localparam int OFF_W       = CFG_W + 2;
    localparam int PROD_W      = 2 * CFG_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP);
    localparam logic [PIX_W:0] STEP_K    = (PIX_W + 1)'(SUBSAMPLE_STEP);
    localparam logic [PIX_W:0] IMG_LIMIT = (PIX_W + 1)'(MAX_IMAGE_SIZE);

    // configuration
    logic [CFG_W-1:0] r_cx, r_cy, r_fx, r_fy, r_zmin, r_zmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= PRINCIPAL_X_RST;
            r_cy   <= PRINCIPAL_Y_RST;
            r_fx   <= FOCAL_X_RST;
            r_fy   <= FOCAL_Y_RST;
            r_zmin <= MIN_DEPTH_RST;
            r_zmax <= MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRINCIPAL_X: r_cx   <= i_cfg_data;
                CFG_PRINCIPAL_Y: r_cy   <= i_cfg_data;
                CFG_FOCAL_X:     r_fx   <= i_cfg_data;
                CFG_FOCAL_Y:     r_fy   <= i_cfg_data;
                CFG_MIN_DEPTH:   r_zmin <= i_cfg_data;
                CFG_MAX_DEPTH:   r_zmax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic t_div div_stage(t_div d, logic [CFG_W-1:0] f);
        t_div       n;
        logic [MAG_W-1:0] t;
        logic       qb;
        n = d;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            t  = {n.rem, n.work[QUOT_W-1]};
            qb = (t >= {1'b0, f});
            if (qb) begin
                n.rem = CFG_W'(t - {1'b0, f});
            end else begin
                n.rem = CFG_W'(t);
            end
            n.work = {n.work[QUOT_W-2:0], qb};
        end
        return n;
    endfunction

    function automatic logic signed [COORD_W-1:0] saturate(t_div d);
        logic signed [COORD_W-1:0] res;
        if (d.zero) begin
            res = '0;
        end else if (d.ovf) begin
            res = d.neg ? NEG_LIMIT : POS_LIMIT;
        end else if (!d.neg) begin
            res = d.work[QUOT_W-1] ? POS_LIMIT : $signed(d.work);
        end else if (d.work > QUOT_W'(NEG_LIMIT)) begin
            res = NEG_LIMIT;
        end else begin
            res = $signed(QUOT_W'(-d.work));
        end
        return res;
    endfunction

    // pipeline control
    logic w_adv;
    logic r_out_v;

    assign w_adv         = !r_out_v || o_point.ready;
    assign i_pixel.ready = w_adv;

    // stage 0: input register
    logic   r_s0_v;
    t_pixel r_s0;

    // stage 1: offsets, range test, grid quotient estimate
    logic             r_s1_v, r_s1_ok;
    logic [PIX_W-1:0] r_s1_row, r_s1_col;
    logic [PIX_W:0]   r_s1_rq, r_s1_cq;
    logic [MAG_W-1:0] r_s1_xmag, r_s1_ymag;
    logic             r_s1_xneg, r_s1_yneg;
    t_side            r_s1_side;

    logic signed [OFF_W-1:0] w_xoff, w_yoff;
    logic [RPROD_W-1:0]      w_rprod, w_cprod;
    logic                    w_s1_ok;

    assign w_xoff  = $signed({2'b00, r_s0.column, 4'b0000}) - $signed({2'b00, r_cx});
    assign w_yoff  = $signed({2'b00, r_s0.row, 4'b0000}) - $signed({2'b00, r_cy});
    assign w_rprod = RPROD_W'(r_s0.row) * RPROD_W'(RECIP);
    assign w_cprod = RPROD_W'(r_s0.column) * RPROD_W'(RECIP);
    assign w_s1_ok = ({1'b0, r_s0.row} < IMG_LIMIT) && ({1'b0, r_s0.column} < IMG_LIMIT)
                  && (r_s0.depth >= r_zmin) && (r_s0.depth <= r_zmax);

    // stage 2: grid test and magnitude products
    logic             r_s2_v;
    logic [PROD_W-1:0] r_s2_xprod, r_s2_yprod;
    logic             r_s2_xneg, r_s2_yneg;
    t_side            r_s2_side;

    logic [PIX_W:0] w_row_back, w_col_back;
    logic           w_on_grid;

    assign w_row_back = (PIX_W + 1)'(r_s1_rq * STEP_K);
    assign w_col_back = (PIX_W + 1)'(r_s1_cq * STEP_K);
    assign w_on_grid  = (w_row_back == {1'b0, r_s1_row}) && (w_col_back == {1'b0, r_s1_col});

    // stage 3 onwards: divider, index 0 holds the quotient overflow check
    logic  r_dv   [DIV_STAGES+1];
    t_div  r_dx   [DIV_STAGES+1];
    t_div  r_dy   [DIV_STAGES+1];
    t_side r_dside[DIV_STAGES+1];

    t_point r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_s0_v  <= i_pixel.valid;
            r_s1_v  <= r_s0_v;
            r_s2_v  <= r_s1_v && r_s1_ok && w_on_grid;
            r_dv[0] <= r_s2_v;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_out_v <= r_dv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= i_pixel.payload;

            r_s1_ok   <= w_s1_ok;
            r_s1_row  <= r_s0.row;
            r_s1_col  <= r_s0.column;
            r_s1_rq   <= w_rprod[RPROD_W-1:RECIP_SHIFT];
            r_s1_cq   <= w_cprod[RPROD_W-1:RECIP_SHIFT];
            r_s1_xneg <= w_xoff[OFF_W-1];
            r_s1_yneg <= w_yoff[OFF_W-1];
            r_s1_xmag <= w_xoff[OFF_W-1] ? MAG_W'(-w_xoff) : MAG_W'(w_xoff);
            r_s1_ymag <= w_yoff[OFF_W-1] ? MAG_W'(-w_yoff) : MAG_W'(w_yoff);
            r_s1_side <= '{z: r_s0.depth, blue: r_s0.blue, green: r_s0.green, red: r_s0.red};

            r_s2_xprod <= PROD_W'(r_s1_xmag) * PROD_W'(r_s1_side.z);
            r_s2_yprod <= PROD_W'(r_s1_ymag) * PROD_W'(r_s1_side.z);
            r_s2_xneg  <= r_s1_xneg;
            r_s2_yneg  <= r_s1_yneg;
            r_s2_side  <= r_s1_side;

            r_dx[0] <= '{neg:  r_s2_xneg,
                         ovf:  ({8'b0, r_s2_xprod[PROD_W-1:QUOT_W]} >= r_fx),
                         zero: (r_s2_xprod == '0),
                         rem:  {8'b0, r_s2_xprod[PROD_W-1:QUOT_W]},
                         work: r_s2_xprod[QUOT_W-1:0]};
            r_dy[0] <= '{neg:  r_s2_yneg,
                         ovf:  ({8'b0, r_s2_yprod[PROD_W-1:QUOT_W]} >= r_fy),
                         zero: (r_s2_yprod == '0),
                         rem:  {8'b0, r_s2_yprod[PROD_W-1:QUOT_W]},
                         work: r_s2_yprod[QUOT_W-1:0]};
            r_dside[0] <= r_s2_side;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_dx[s]    <= div_stage(r_dx[s-1], r_fx);
                r_dy[s]    <= div_stage(r_dy[s-1], r_fy);
                r_dside[s] <= r_dside[s-1];
            end

            r_out.point_x   <= saturate(r_dx[DIV_STAGES]);
            r_out.point_y   <= saturate(r_dy[DIV_STAGES]);
            r_out.point_z   <= r_dside[DIV_STAGES].z;
            r_out.out_blue  <= r_dside[DIV_STAGES].blue;
            r_out.out_green <= r_dside[DIV_STAGES].green;
            r_out.out_red   <= r_dside[DIV_STAGES].red;
        end
    end

    assign o_point.valid   = r_out_v;
    assign o_point.payload = r_out;

endmodule

`default_nettype wire
